[hw/rtl/isd_pkg.sv]
// shared types, widths and defaults of the index shuffle and draw engine
package isd_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam int RANDOM_BITS_DEF = 16;

	localparam int CLASS_SIZE_W   = 6;
	localparam int RANDOM_WORD_W  = 16;
	localparam int PICKED_INDEX_W = 5;

	localparam logic [CLASS_SIZE_W-1:0] CLASS_SIZE_RESET = 6'd1;

	localparam logic MODE_SHUFFLE = 1'b0;
	localparam logic MODE_DRAW    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD_I,
		ST_RD_J,
		ST_WR_I,
		ST_WR_J,
		ST_DRAW_RD,
		ST_DRAW_DT,
		ST_FIN
	} state_t;

endpackage

[hw/rtl/isd_cfg_if.sv]
// configuration write channel carrying class_size
interface isd_cfg_if import isd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CLASS_SIZE_W-1:0] class_size;

	modport source (output valid, output class_size, input ready);
	modport sink   (input valid, input class_size, output ready);
endinterface

[hw/rtl/isd_in_if.sv]
// input item channel: mode and random word
interface isd_in_if import isd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic [RANDOM_WORD_W-1:0] random_word;

	modport source (output valid, output mode, output random_word, input ready);
	modport sink   (input valid, input mode, input random_word, output ready);
endinterface

[hw/rtl/isd_out_if.sv]
// result item channel: picked index and flags
interface isd_out_if import isd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [PICKED_INDEX_W-1:0] picked_index;
	logic                      pick_valid;
	logic                      shuffle_done;

	modport source (output valid, output picked_index, output pick_valid,
		output shuffle_done, input ready);
	modport sink   (input valid, input picked_index, input pick_valid,
		input shuffle_done, output ready);
endinterface

[hw/rtl/isd_ram.sv]
// generic single write port, single read port ram with registered read
module isd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[hw/rtl/index_shuffle_and_draw.sv]
// top level of the index shuffle and draw engine
// Random permutation engine over a table of up to MAX_ENTRIES indices, one
// item at a time. A shuffle step (mode 0) takes the remainder by (size - i)
// from a bit-serial restoring divider over a DIV_W-bit dividend, where
// DIV_W is the larger of the used random bits (at most 16) and the cursor
// width plus one; the divider consumes one dividend bit per cycle. Two
// reads and two writes on the table ram (one write and one read port) then
// do the swap. A valid draw (mode 1) goes through the same divider for the
// cursor wrap and one table read; a draw before the shuffle is done skips
// both and answers with its pick valid flag clear. A new item
// is taken once the previous one has moved to the output register, so a
// waiting result does not hold off the next item. The table comes out of
// reset in identity order through per-entry valid bits, with no clearing
// pass; the first step of every pass restores identity order the same way.
module index_shuffle_and_draw import isd_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	isd_cfg_if.sink   cfg,
	isd_in_if.sink    cmd,
	isd_out_if.source res
);
	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int SZ_MAX = (MAX_ENTRIES < 63) ? MAX_ENTRIES : 63;
	localparam int SZ_W   = $clog2(SZ_MAX + 1);
	localparam int RND_W  = (RANDOM_BITS < RANDOM_WORD_W) ? RANDOM_BITS : RANDOM_WORD_W;
	localparam int DIV_W  = (RND_W > IDX_W + 1) ? RND_W : IDX_W + 1;
	localparam int CNT_W  = $clog2(DIV_W);
	localparam int SUM_W  = ((IDX_W > SZ_W) ? IDX_W : SZ_W) + 1;

	state_t state_q, state_d;

	logic                      op_draw_q;
	logic [DIV_W-1:0]          dvd_q;
	logic [SZ_W-1:0]           rem_q;
	logic [SZ_W-1:0]           dvs_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [IDX_W-1:0]          i_q;
	logic [IDX_W-1:0]          j_q;
	logic [IDX_W-1:0]          ti_q;
	logic [SZ_W-1:0]           pos_q;
	logic [IDX_W-1:0]          cursor_q;
	logic                      done_q;
	logic [CLASS_SIZE_W-1:0]   cs_q;
	logic [MAX_ENTRIES-1:0]    vld_q;
	logic                      rd_vld_q;
	logic [IDX_W-1:0]          rd_addr_q;
	logic [PICKED_INDEX_W-1:0] res_pick_q;
	logic                      res_valid_q;
	logic                      out_valid_q;
	logic [PICKED_INDEX_W-1:0] out_pick_q;
	logic                      out_pv_q;
	logic                      out_done_q;

	logic              acc;
	logic              out_load;
	logic [SZ_W-1:0]   size;
	logic [SZ_W-1:0]   pos_eff;
	logic [SZ_W:0]     rem_sh;
	logic [SZ_W-1:0]   rem_nx;
	logic [IDX_W:0]    cur_inc;
	logic [SZ_W:0]     pos_inc;
	logic [SUM_W-1:0]  j_sum;
	logic              div_last;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [IDX_W-1:0]  ram_rdata;
	logic [IDX_W-1:0]  rd_value;

	isd_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// effective size: zero acts as one, clamp to table depth
	always_comb begin
		if (cs_q == '0) begin
			size = SZ_W'(1);
		end else if ({26'd0, cs_q} > MAX_ENTRIES) begin
			size = SZ_W'(MAX_ENTRIES);
		end else begin
			size = SZ_W'(cs_q);
		end
	end

	assign pos_eff  = (pos_q >= size) ? '0 : pos_q;
	assign acc      = cmd.valid && cmd.ready;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || res.ready);
	assign rem_sh   = {rem_q, dvd_q[DIV_W-1]};
	assign rem_nx   = (rem_sh >= {1'b0, dvs_q}) ? SZ_W'(rem_sh - {1'b0, dvs_q})
		: SZ_W'(rem_sh);
	assign cur_inc  = {1'b0, cursor_q} + (IDX_W+1)'(1);
	assign pos_inc  = (SZ_W+1)'(SZ_W'(i_q)) + (SZ_W+1)'(1);
	assign j_sum    = SUM_W'(i_q) + SUM_W'(rem_q);
	assign div_last = (cnt_q == CNT_W'(DIV_W - 1));
	assign rd_value = rd_vld_q ? ram_rdata : rd_addr_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (cmd.mode == MODE_SHUFFLE || done_q) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = op_draw_q ? ST_DRAW_RD : ST_RD_I;
				end
			end
			ST_RD_I:    state_d = ST_RD_J;
			ST_RD_J:    state_d = ST_WR_I;
			ST_WR_I:    state_d = ST_WR_J;
			ST_WR_J:    state_d = ST_FIN;
			ST_DRAW_RD: state_d = ST_DRAW_DT;
			ST_DRAW_DT: state_d = ST_FIN;
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = rd_value;
		ram_re    = 1'b0;
		ram_raddr = i_q;
		case (state_q)
			ST_IDLE: cmd.ready = 1'b1;
			ST_RD_I: begin
				ram_re    = 1'b1;
				ram_raddr = i_q;
			end
			ST_RD_J: begin
				ram_re    = 1'b1;
				ram_raddr = j_q;
			end
			ST_WR_I: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = rd_value;
			end
			ST_WR_J: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = ti_q;
			end
			ST_DRAW_RD: begin
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(rem_q);
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	assign cfg.ready        = 1'b1;
	assign res.valid        = out_valid_q;
	assign res.picked_index = out_pick_q;
	assign res.pick_valid   = out_pv_q;
	assign res.shuffle_done = out_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cursor_q    <= '0;
			done_q      <= 1'b0;
			cs_q        <= CLASS_SIZE_RESET;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				cs_q <= cfg.class_size;
			end
			if (acc && cmd.mode == MODE_SHUFFLE && pos_eff == '0) begin
				// new pass: table back to identity order
				vld_q  <= '0;
				done_q <= 1'b0;
			end
			if (state_q == ST_WR_I) begin
				vld_q[i_q] <= 1'b1;
			end
			if (state_q == ST_WR_J) begin
				vld_q[j_q] <= 1'b1;
				if (pos_inc >= (SZ_W+1)'(size)) begin
					pos_q  <= '0;
					done_q <= 1'b1;
				end else begin
					pos_q  <= SZ_W'(pos_inc);
				end
			end
			if (state_q == ST_DRAW_RD) begin
				cursor_q <= IDX_W'(rem_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			op_draw_q   <= (cmd.mode == MODE_DRAW);
			rem_q       <= '0;
			cnt_q       <= '0;
			res_pick_q  <= '0;
			res_valid_q <= 1'b0;
			i_q         <= IDX_W'(pos_eff);
			if (cmd.mode == MODE_SHUFFLE) begin
				dvd_q <= DIV_W'(cmd.random_word[RND_W-1:0]);
				dvs_q <= size - pos_eff;
			end else begin
				dvd_q <= DIV_W'(cur_inc);
				dvs_q <= size;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (state_q == ST_RD_I) begin
			j_q <= IDX_W'(j_sum);
		end
		if (state_q == ST_RD_J) begin
			ti_q <= rd_value;
		end
		if (state_q == ST_DRAW_DT) begin
			res_pick_q  <= PICKED_INDEX_W'(rd_value);
			res_valid_q <= 1'b1;
		end
		if (ram_re) begin
			rd_vld_q  <= vld_q[ram_raddr];
			rd_addr_q <= ram_raddr;
		end
		if (out_load) begin
			out_pick_q <= res_pick_q;
			out_pv_q   <= res_valid_q;
			out_done_q <= done_q;
		end
	end

	a_pick_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.pick_valid && !res.shuffle_done))
		else $error("valid pick reported without a finished shuffle");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dvs_q != '0 && rem_q < dvs_q))
		else $error("divider remainder out of range");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_J) |-> (j_q >= i_q && $past(state_q) == ST_WR_I))
		else $error("swap partner below current position");

	a_draw_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_DT) |-> (SZ_W'(cursor_q) < size))
		else $error("draw cursor not below size");
endmodule
